[rtl/core/ght_pkg.sv]
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants of the generational handle table: operation and
// status codes, fixed field widths and the slot memory write controls.
// ----------------------------------------------------------------------------
package ght_pkg;

  // Fixed field widths of the handle and result ports
  localparam int IDX_PORT_W = 8;
  localparam int GEN_W      = 16;
  localparam int PAY_PORT_W = 32;
  localparam int CNT_PORT_W = 9;

  // First generation issued after a wrap (zero is never a valid generation)
  localparam logic [GEN_W-1:0] GEN_ONE = GEN_W'(1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // Write enables toward the slot memories
  typedef struct packed {
    logic link_we;
    logic gen_we;
    logic live_we;
    logic pay_we;
    logic live_val;
  } wr_ctl_t;

endpackage

[rtl/core/generational_handle_table.sv]
// Generational handle table. Each operation (add, remove, get, update) first
// issues one read of the slot memories at the transfer; then, once the output
// register can take the result, the slot is checked, modified and written back
// while the result is loaded into the output register. The next operation is
// taken only once the write-back is done, so operations never overlap in the
// single read-modify-write of the slot memory. The output register frees the
// input side while a result waits. After reset a sweep initializes the slot
// memories, during which in_ready stays low.
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot map handing out (index, generation) handles from a linked free list,
// with a payload per slot and a live count reported with every result.
// ----------------------------------------------------------------------------
module generational_handle_table
  import ght_pkg::*;
#(
  parameter int SLOTS        = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // operation channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_operation,
  input  logic [IDX_PORT_W-1:0] in_handle_index,
  input  logic [GEN_W-1:0]      in_handle_generation,
  input  logic [PAY_PORT_W-1:0] in_payload_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [IDX_PORT_W-1:0] out_index,
  output logic [GEN_W-1:0]      out_generation,
  output logic [PAY_PORT_W-1:0] out_payload_out,
  output logic [CNT_PORT_W-1:0] out_live_entries
);

  localparam int IdxW   = $clog2(SLOTS);
  localparam int CntW   = $clog2(SLOTS + 1);
  localparam int StoreW = (PAYLOAD_BITS < PAY_PORT_W) ? PAYLOAD_BITS : PAY_PORT_W;
  localparam logic [CntW-1:0] FullCnt = CntW'(SLOTS);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                state_r, state_nxt;

  // operation held for the execute cycle
  op_t                   op_r;
  logic [IdxW-1:0]       idx_r;
  logic [GEN_W-1:0]      gen_r;
  logic [StoreW-1:0]     pay_r;
  logic                  in_range_r;

  // table-wide state
  logic [IdxW-1:0]       free_head_r, free_head_nxt;
  logic [CntW-1:0]       live_count_r, live_count_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  status_t               status_r, status_nxt;
  logic [IDX_PORT_W-1:0] oidx_r, oidx_nxt;
  logic [GEN_W-1:0]      ogen_r, ogen_nxt;
  logic [PAY_PORT_W-1:0] opay_r, opay_nxt;
  logic [CNT_PORT_W-1:0] ocnt_r, ocnt_nxt;

  // memory interface
  logic                  mem_busy;
  logic                  rd_en;
  logic [IdxW-1:0]       rd_addr;
  logic [IdxW-1:0]       rd_link;
  logic [GEN_W-1:0]      rd_gen;
  logic                  rd_live;
  logic [StoreW-1:0]     rd_pay;
  wr_ctl_t               wr_ctl, wr_req;
  logic [GEN_W-1:0]      gen_inc, gen_new;
  logic                  handle_ok;
  logic                  is_full;
  logic                  fire;
  logic                  in_xfer;
  op_t                   in_op;

  assign in_op   = op_t'(in_operation);
  assign in_ready = (state_r == S_IDLE) && !mem_busy;
  assign in_xfer  = in_valid && in_ready;

  // Read the free head for add, the handle's slot otherwise
  assign rd_en   = in_xfer;
  assign rd_addr = (in_op == OP_ADD) ? free_head_r : IdxW'(in_handle_index);

  // Execute once the result register can take the result
  assign fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign is_full   = (live_count_r == FullCnt);
  assign handle_ok = in_range_r && rd_live && (rd_gen == gen_r);
  assign gen_inc   = rd_gen + 1'b1;
  assign gen_new   = (gen_inc == '0) ? GEN_ONE : gen_inc;

  // Check the slot and build the write-back and result
  always_comb begin
    wr_req         = '0;
    status_nxt     = ST_OK;
    oidx_nxt       = '0;
    ogen_nxt       = '0;
    opay_nxt       = '0;
    free_head_nxt  = free_head_r;
    live_count_nxt = live_count_r;
    unique case (op_r)
      OP_ADD: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_req.gen_we   = 1'b1;
          wr_req.live_we  = 1'b1;
          wr_req.live_val = 1'b1;
          wr_req.pay_we   = 1'b1;
          free_head_nxt   = rd_link;
          live_count_nxt  = live_count_r + 1'b1;
          oidx_nxt        = IDX_PORT_W'(idx_r);
          ogen_nxt        = gen_new;
        end
      end
      OP_REMOVE: begin
        if (!handle_ok) begin
          status_nxt = ST_BAD;
        end else begin
          wr_req.link_we = 1'b1;
          wr_req.live_we = 1'b1;
          free_head_nxt  = idx_r;
          live_count_nxt = live_count_r - 1'b1;
        end
      end
      OP_GET: begin
        if (!handle_ok) begin
          status_nxt = ST_BAD;
        end else begin
          opay_nxt = PAY_PORT_W'(rd_pay);
        end
      end
      OP_UPDATE: begin
        if (!handle_ok) begin
          status_nxt = ST_BAD;
        end else begin
          wr_req.pay_we = 1'b1;
        end
      end
      default: begin
        status_nxt = ST_BAD;
      end
    endcase
    ocnt_nxt = CNT_PORT_W'(live_count_nxt);
  end

  // Gate the write-back with the execute strobe
  assign wr_ctl = fire ? wr_req : '0;

  // Sequence and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, table counters and the result register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r       <= in_op;
      idx_r      <= (in_op == OP_ADD) ? free_head_r : IdxW'(in_handle_index);
      gen_r      <= in_handle_generation;
      pay_r      <= StoreW'(in_payload_in);
      in_range_r <= (32'(in_handle_index) < SLOTS);
    end
    if (fire) begin
      status_r <= status_nxt;
      oidx_r   <= oidx_nxt;
      ogen_r   <= ogen_nxt;
      opay_r   <= opay_nxt;
      ocnt_r   <= ocnt_nxt;
    end
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      free_head_r  <= '0;
      live_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        free_head_r  <= free_head_nxt;
        live_count_r <= live_count_nxt;
      end
    end
  end

  ght_slot_mem #(
    .SLOTS      (SLOTS),
    .STORE_BITS (StoreW)
  ) u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_link (rd_link),
    .rd_gen  (rd_gen),
    .rd_live (rd_live),
    .rd_pay  (rd_pay),
    .wr_ctl  (wr_ctl),
    .wr_addr (idx_r),
    .wr_link (free_head_r),
    .wr_gen  (gen_new),
    .wr_pay  (pay_r),
    .busy    (mem_busy)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_index        = oidx_r;
  assign out_generation   = ogen_r;
  assign out_payload_out  = opay_r;
  assign out_live_entries = ocnt_r;

  // Live count never exceeds the table size
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    live_count_r <= FullCnt)
    else $error("live count above table size");

  // No operation is taken during the initialization sweep
  a_no_xfer_busy : assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> !in_ready)
    else $error("operation taken while memories initialize");

  // A successful add raises the live count by one
  a_add_count : assert property (@(posedge clk) disable iff (!rst_n)
    (fire && op_r == OP_ADD && !is_full) |=>
      live_count_r == $past(live_count_r) + CntW'(1))
    else $error("add did not advance live count");

  // An executed operation always leaves a result waiting
  a_fire_result : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && state_r == S_IDLE)
    else $error("executed operation left no result");

endmodule

[rtl/core/ght_slot_mem.sv]
// ----------------------------------------------------------------------------
// ght_slot_mem
// Per-slot storage: free-list link, generation, live flag and payload, each a
// synchronous memory with one registered read port. After reset a sweep
// writes the initial link, generation and live values into every slot.
// ----------------------------------------------------------------------------
module ght_slot_mem
  import ght_pkg::*;
#(
  parameter int SLOTS      = 256,
  parameter int STORE_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // read port
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [$clog2(SLOTS)-1:0] rd_link,
  output logic [GEN_W-1:0]         rd_gen,
  output logic                     rd_live,
  output logic [STORE_BITS-1:0]    rd_pay,
  // write port
  input  wr_ctl_t                  wr_ctl,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [$clog2(SLOTS)-1:0] wr_link,
  input  logic [GEN_W-1:0]         wr_gen,
  input  logic [STORE_BITS-1:0]    wr_pay,
  // initialization sweep in progress
  output logic                     busy
);

  localparam int IdxW = $clog2(SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  logic [IdxW-1:0]       link_mem [SLOTS];
  logic [GEN_W-1:0]      gen_mem  [SLOTS];
  logic                  live_mem [SLOTS];
  logic [STORE_BITS-1:0] pay_mem  [SLOTS];

  logic [IdxW-1:0]       clr_idx_r;
  logic                  clr_busy_r;
  logic [IdxW-1:0]       clr_link;

  logic [IdxW-1:0]       rd_link_r;
  logic [GEN_W-1:0]      rd_gen_r;
  logic                  rd_live_r;
  logic [STORE_BITS-1:0] rd_pay_r;

  // Link of a fresh slot: next index, last slot back to zero
  assign clr_link = (clr_idx_r == LastIdx) ? '0 : clr_idx_r + 1'b1;

  // Advance the initialization sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_link;
      if (clr_idx_r == LastIdx) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Write link, generation and live: sweep first, then operations
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      link_mem[clr_idx_r] <= clr_link;
      gen_mem[clr_idx_r]  <= GEN_ONE;
      live_mem[clr_idx_r] <= 1'b0;
    end else begin
      if (wr_ctl.link_we) begin
        link_mem[wr_addr] <= wr_link;
      end
      if (wr_ctl.gen_we) begin
        gen_mem[wr_addr] <= wr_gen;
      end
      if (wr_ctl.live_we) begin
        live_mem[wr_addr] <= wr_ctl.live_val;
      end
    end
  end

  // Write payload (never swept: only payloads of live slots are returned)
  always_ff @(posedge clk) begin
    if (wr_ctl.pay_we) begin
      pay_mem[wr_addr] <= wr_pay;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_link_r <= link_mem[rd_addr];
      rd_gen_r  <= gen_mem[rd_addr];
      rd_live_r <= live_mem[rd_addr];
      rd_pay_r  <= pay_mem[rd_addr];
    end
  end

  assign rd_link = rd_link_r;
  assign rd_gen  = rd_gen_r;
  assign rd_live = rd_live_r;
  assign rd_pay  = rd_pay_r;
  assign busy    = clr_busy_r;

endmodule

[tb/ght_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ght_tb_pkg
// Slot-table predictor and result scoreboard for the generational handle
// table testbench. It tracks free list, generations, live flags and payloads,
// and checks each result transfer against the oldest predicted result.
// ----------------------------------------------------------------------------
package ght_tb_pkg;
  import ght_pkg::*;

  localparam int NSLOTS = 256;

  typedef struct packed {
    logic [1:0]            status;
    logic [IDX_PORT_W-1:0] index;
    logic [GEN_W-1:0]      generation;
    logic [PAY_PORT_W-1:0] payload;
    logic [CNT_PORT_W-1:0] live;
  } table_result_t;

  class handle_table_scoreboard;
    logic [IDX_PORT_W-1:0] free_link [NSLOTS];
    logic [GEN_W-1:0]      slot_gen [NSLOTS];
    bit                    slot_live [NSLOTS];
    logic [PAY_PORT_W-1:0] slot_payload [NSLOTS];
    logic [IDX_PORT_W-1:0] free_head;
    int unsigned           live_count;
    table_result_t         expected_q [$];
    logic [IDX_PORT_W-1:0] last_index;
    logic [GEN_W-1:0]      last_gen;
    int unsigned           errors;
    int unsigned           op_count [4];
    int unsigned           full_count;
    int unsigned           stale_count;
    int unsigned           wrap_count;
    int unsigned           peak_live;

    function new();
      for (int i = 0; i < NSLOTS; i++) begin
        free_link[i]    = IDX_PORT_W'((i + 1) % NSLOTS);
        slot_gen[i]     = GEN_ONE;
        slot_live[i]    = 1'b0;
        slot_payload[i] = '0;
      end
      free_head   = '0;
      live_count  = 0;
      last_index  = '0;
      last_gen    = '0;
      errors      = 0;
      full_count  = 0;
      stale_count = 0;
      wrap_count  = 0;
      peak_live   = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted operation to the table and queue its result
    function void note_op(op_t op, logic [IDX_PORT_W-1:0] idx, logic [GEN_W-1:0] gen,
                          logic [PAY_PORT_W-1:0] pay);
      table_result_t         res;
      logic [IDX_PORT_W-1:0] s;
      res = '0;
      res.status = ST_OK;
      op_count[op]++;
      if (op == OP_ADD) begin
        if (live_count >= NSLOTS) begin
          res.status = ST_FULL;
          full_count++;
        end else begin
          s = free_head;
          free_head = free_link[s];
          free_link[s] = '0;
          // zero is never issued: wrap straight to one
          if (slot_gen[s] == '1) begin
            slot_gen[s] = GEN_ONE;
            wrap_count++;
          end else begin
            slot_gen[s] = slot_gen[s] + 1'b1;
          end
          slot_live[s] = 1'b1;
          slot_payload[s] = pay;
          live_count++;
          res.index = s;
          res.generation = slot_gen[s];
          last_index = s;
          last_gen = slot_gen[s];
        end
      end else if (!slot_live[idx] || slot_gen[idx] != gen) begin
        res.status = ST_BAD;
        stale_count++;
      end else begin
        case (op)
          OP_REMOVE: begin
            free_link[idx] = free_head;
            slot_live[idx] = 1'b0;
            free_head = idx;
            live_count--;
          end
          OP_GET: begin
            res.payload = slot_payload[idx];
          end
          default: begin
            slot_payload[idx] = pay;
          end
        endcase
      end
      res.live = CNT_PORT_W'(live_count);
      if (live_count > peak_live) peak_live = live_count;
      expected_q.push_back(res);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(table_result_t got);
      table_result_t want;
      string         diff;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: unexpected result status %0d index %0d gen %0d data %h live %0d",
                   $time, got.status, got.index, got.generation, got.payload, got.live);
        return;
      end
      want = expected_q.pop_front();
      diff = "";
      if (got.status !== want.status) diff = {diff, " status"};
      if (got.index !== want.index) diff = {diff, " index"};
      if (got.generation !== want.generation) diff = {diff, " generation"};
      if (got.payload !== want.payload) diff = {diff, " payload"};
      if (got.live !== want.live) diff = {diff, " live_entries"};
      if (diff != "") begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR %0t: result mismatch in%s", $time, diff);
          $display("  expected status %0d index %0d gen %0d data %h live %0d",
                   want.status, want.index, want.generation, want.payload, want.live);
          $display("  actual   status %0d index %0d gen %0d data %h live %0d",
                   got.status, got.index, got.generation, got.payload, got.live);
        end
      end
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the generational handle table. Drives add, remove, get and
// update operations (directed corners, random mixes, a full-table phase and
// repeated recycling of one slot) with random stalls on both channels, and
// checks every result against the scoreboard's slot-table predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import ght_pkg::*;
  import ght_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_operation = OP_ADD;
  logic [IDX_PORT_W-1:0] in_handle_index = '0;
  logic [GEN_W-1:0]      in_handle_generation = '0;
  logic [PAY_PORT_W-1:0] in_payload_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_status;
  logic [IDX_PORT_W-1:0] out_index;
  logic [GEN_W-1:0]      out_generation;
  logic [PAY_PORT_W-1:0] out_payload_out;
  logic [CNT_PORT_W-1:0] out_live_entries;

  handle_table_scoreboard sb;
  bit                     idling_on = 1'b0;
  int unsigned            stall_left = 0;

  generational_handle_table i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_handle_index      (in_handle_index),
    .in_handle_generation (in_handle_generation),
    .in_payload_in        (in_payload_in),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_index            (out_index),
    .out_generation       (out_generation),
    .out_payload_out      (out_payload_out),
    .out_live_entries     (out_live_entries)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result channel in random bursts while idling_on is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_status, out_index, out_generation, out_payload_out,
                       out_live_entries});
  end

  // End the run when no transfer happens for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [PAY_PORT_W-1:0] rand_payload();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PAY_PORT_W'($urandom);
    endcase
  endfunction

  // Find a live handle from a random starting slot
  function automatic bit pick_live(output logic [IDX_PORT_W-1:0] idx,
                                   output logic [GEN_W-1:0] gen);
    int unsigned start;
    int unsigned s;
    start = $urandom_range(0, NSLOTS - 1);
    for (int k = 0; k < NSLOTS; k++) begin
      s = (start + k) % NSLOTS;
      if (sb.slot_live[s]) begin
        idx = IDX_PORT_W'(s);
        gen = sb.slot_gen[s];
        return 1'b1;
      end
    end
    idx = IDX_PORT_W'($urandom);
    gen = GEN_W'($urandom);
    return 1'b0;
  endfunction

  // Find a free slot and pair it with its current generation
  function automatic void pick_free(output logic [IDX_PORT_W-1:0] idx,
                                    output logic [GEN_W-1:0] gen);
    int unsigned start;
    int unsigned s;
    start = $urandom_range(0, NSLOTS - 1);
    idx = IDX_PORT_W'($urandom);
    gen = GEN_W'($urandom);
    for (int k = 0; k < NSLOTS; k++) begin
      s = (start + k) % NSLOTS;
      if (!sb.slot_live[s]) begin
        idx = IDX_PORT_W'(s);
        gen = sb.slot_gen[s];
        return;
      end
    end
  endfunction

  // Present one operation, hold it until the transfer, then record it
  task automatic send_op(input op_t op, input logic [IDX_PORT_W-1:0] idx,
                         input logic [GEN_W-1:0] gen, input logic [PAY_PORT_W-1:0] pay);
    int unsigned gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_operation         <= op;
    in_handle_index      <= idx;
    in_handle_generation <= gen;
    in_payload_in        <= pay;
    do @(posedge clk); while (!in_ready);
    sb.note_op(op, idx, gen, pay);
  endtask

  // Hold the sender until every predicted result has come back
  task automatic wait_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One random operation: adds, well-formed handle ops and stale/noise handles
  task automatic random_op(input int unsigned add_pct, input int unsigned rem_pct,
                           input int unsigned noise_pct);
    int unsigned           pick;
    int unsigned           kind;
    logic [IDX_PORT_W-1:0] idx;
    logic [GEN_W-1:0]      gen;
    op_t                   op;
    pick = $urandom_range(0, 99);
    idx = IDX_PORT_W'($urandom);
    gen = GEN_W'($urandom);
    if (pick < add_pct) begin
      op = OP_ADD;
    end else if (pick < add_pct + noise_pct) begin
      op = op_t'($urandom_range(1, 3));
      kind = $urandom_range(0, 3);
      if (kind == 1) begin
        // live slot, neighboring generation
        if (pick_live(idx, gen)) gen = gen + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
      end else if (kind == 2) begin
        pick_free(idx, gen);
      end
    end else if (pick_live(idx, gen)) begin
      if ($urandom_range(0, 99) < rem_pct) op = OP_REMOVE;
      else op = $urandom_range(0, 1) ? OP_GET : OP_UPDATE;
    end else begin
      op = OP_ADD;
    end
    send_op(op, idx, gen, rand_payload());
  endtask

  task automatic directed_ops();
    logic [IDX_PORT_W-1:0] h0;
    logic [IDX_PORT_W-1:0] h1;
    logic [GEN_W-1:0]      g0;
    logic [GEN_W-1:0]      g1;
    // handles on an empty table
    send_op(OP_GET, 8'd0, 16'd1, '0);
    send_op(OP_REMOVE, 8'd0, 16'd1, '0);
    send_op(OP_UPDATE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    // add, then use the new handle right away
    send_op(OP_ADD, 8'hFF, 16'hFFFF, 32'h0000_0000);
    h0 = sb.last_index;
    g0 = sb.last_gen;
    send_op(OP_GET, h0, g0, '0);
    send_op(OP_ADD, 8'h00, 16'h0000, 32'hFFFF_FFFF);
    h1 = sb.last_index;
    g1 = sb.last_gen;
    send_op(OP_GET, h1, g1, '0);
    // neighboring generations are stale
    send_op(OP_GET, h1, g1 - 1'b1, '0);
    send_op(OP_GET, h1, g1 + 1'b1, '0);
    send_op(OP_UPDATE, h1, g1, 32'h8000_0001);
    send_op(OP_GET, h1, g1, '0);
    send_op(OP_UPDATE, h0, g0 ^ 16'h8000, 32'h1234_5678);
    send_op(OP_GET, h0, g0, '0);
    // remove, then every op on the dead handle
    send_op(OP_REMOVE, h1, g1, '0);
    send_op(OP_REMOVE, h1, g1, '0);
    send_op(OP_GET, h1, g1, '0);
    send_op(OP_UPDATE, h1, g1, 32'hDEAD_BEEF);
    // recycle the freed slot under a new generation
    send_op(OP_ADD, 8'h5A, 16'hA5A5, 32'h5A5A_A5A5);
    send_op(OP_GET, sb.last_index, sb.last_gen, '0);
    send_op(OP_GET, h1, g1, '0);
    send_op(OP_REMOVE, h0, g0, '0);
    send_op(OP_REMOVE, sb.last_index, sb.last_gen, '0);
  endtask

  // Fill every slot, then hit the full table with adds and lookups
  task automatic fill_table();
    while (sb.live_count < NSLOTS) begin
      if ($urandom_range(0, 3) == 0) random_op(0, 0, 20);
      else send_op(OP_ADD, IDX_PORT_W'($urandom), GEN_W'($urandom), rand_payload());
    end
    repeat (12) random_op(25, 0, 30);
  endtask

  // Cycle the free-list head through add and remove several times
  task automatic recycle_slot();
    logic [IDX_PORT_W-1:0] idx;
    logic [GEN_W-1:0]      gen;
    logic [IDX_PORT_W-1:0] s;
    logic [GEN_W-1:0]      old_gen;
    if (sb.live_count >= NSLOTS && pick_live(idx, gen)) send_op(OP_REMOVE, idx, gen, '0);
    s = sb.free_head;
    old_gen = sb.slot_gen[s];
    repeat (8) begin
      send_op(OP_ADD, IDX_PORT_W'($urandom), GEN_W'($urandom), rand_payload());
      if ($urandom_range(0, 3) == 0) send_op(OP_GET, s, sb.slot_gen[s], '0);
      send_op(OP_REMOVE, s, sb.slot_gen[s], PAY_PORT_W'($urandom));
    end
    send_op(OP_GET, s, old_gen, '0);
    send_op(OP_GET, s, 16'h0000, '0);
    send_op(OP_ADD, '0, '0, rand_payload());
    send_op(OP_GET, sb.last_index, sb.last_gen, '0);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_ops();

    idling_on = 1'b1;
    repeat (120) random_op(35, 30, 20);
    fill_table();
    wait_results();
    repeat (60) random_op(10, 60, 15);

    // last part runs without stalls
    idling_on = 1'b0;
    recycle_slot();
    repeat (20) random_op(30, 30, 20);

    wait_results();
    repeat (8) @(posedge clk);

    $display("Covered %0d ops (add %0d, remove %0d, get %0d, update %0d), %0d full adds,",
             sb.op_count[0] + sb.op_count[1] + sb.op_count[2] + sb.op_count[3],
             sb.op_count[OP_ADD], sb.op_count[OP_REMOVE], sb.op_count[OP_GET],
             sb.op_count[OP_UPDATE], sb.full_count);
    $display("%0d stale handles, %0d generation wraps, peak of %0d live slots; %0d errors.",
             sb.stale_count, sb.wrap_count, sb.peak_live, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[generational_handle_table.f]
rtl/core/ght_pkg.sv
rtl/core/ght_slot_mem.sv
rtl/core/generational_handle_table.sv
tb/ght_tb_pkg.sv
tb/tb_top.sv
